// ===== hw/rtl/cross_correlation_lag_search_assert.svh =====
// ----------------------------------------------------------------------------
// Cross-correlation lag search assertion macros
// Shared property wrappers that sample on i_clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CROSS_CORRELATION_LAG_SEARCH_ASSERT_SVH
`define CROSS_CORRELATION_LAG_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCLAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCLAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cclag_pkg.sv =====
// ----------------------------------------------------------------------------
// Cross-correlation lag search package
// Sizes, widths, job and release records and the search state type.
// ----------------------------------------------------------------------------
package cclag_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int LAG_RANGE   = 25;

    localparam int RAW_W       = 24;
    localparam int SMP_W       = 16;
    localparam int TRUNC_SHIFT = 8;
    localparam int THR_W       = 39;
    localparam int ENERGY_W    = 40;
    localparam int SCORE_W     = 40;
    localparam int LAG_OUT_W   = 6;

    localparam logic [THR_W-1:0] THR_RESET = 39'd400000000;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int RAM_AW    = ADDR_W + 1;
    localparam int RAM_DEPTH = 2 * (2 ** ADDR_W);

    localparam int LAG_W = $clog2(LAG_RANGE) + 1;
    localparam int IDX_W = ((CNT_W > LAG_W) ? CNT_W : LAG_W) + 2;

    localparam int PROD_W = 2 * SMP_W;
    localparam int SQ_W   = 2 * SMP_W;
    localparam int ACC_RAW_W = PROD_W + ADDR_W + 1;
    localparam int ACC_W  = (ACC_RAW_W > SCORE_W + 1) ? ACC_RAW_W : SCORE_W + 1;

    localparam logic signed [LAG_W-1:0] FIRST_LAG = LAG_W'(-LAG_RANGE);
    localparam logic signed [LAG_W-1:0] LAST_LAG  = LAG_W'(LAG_RANGE - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = ((2 * RAW_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = LAG_OUT_W + SCORE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             silent;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_ISSUE,
        BK_DRAIN,
        BK_OUTPUT
    } t_back_state;

endpackage

// ===== hw/rtl/cclag_ram.sv =====
// ----------------------------------------------------------------------------
// Generic sample RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cclag_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/cclag_queue.sv =====
// ----------------------------------------------------------------------------
// Search job queue
// Short first-in first-out queue of finished batches awaiting the search.
// ----------------------------------------------------------------------------
`include "cross_correlation_lag_search_assert.svh"

module cclag_queue
    import cclag_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CCLAG_ASSERT_NOW(a_no_overflow, i_push, r_count != QCNT_W'(QUEUE_DEPTH),
        "job pushed into a full queue")

endmodule

// ===== hw/rtl/cclag_front.sv =====
// ----------------------------------------------------------------------------
// Cross-correlation lag search front end
// Accepts sample pairs, stores them in the free bank, sums the reference
// energy and hands each finished batch to the search queue.
// ----------------------------------------------------------------------------
module cclag_front
    import cclag_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wen,
    input  logic [THR_W-1:0]         i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [RAW_W-1:0]  i_ref_raw,
    input  logic signed [RAW_W-1:0]  i_mic_raw,
    input  logic                     i_last,
    output logic                     o_wr_en,
    output logic [RAM_AW-1:0]        o_wr_addr,
    output logic [SMP_W-1:0]         o_ref_wr_data,
    output logic [SMP_W-1:0]         o_mic_wr_data,
    input  t_release                 i_release,
    output logic                     o_push,
    output t_job                     o_push_job
);

    logic [THR_W-1:0]    r_thr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_wbank;
    logic [1:0]          r_busy;
    logic [1:0]          n_busy;
    logic [ENERGY_W-1:0] r_energy;
    logic [ENERGY_W-1:0] n_energy;

    logic                r_s1_valid;
    logic                r_s1_store;
    logic                r_s1_last;
    logic                r_s1_bank;
    logic [CNT_W-1:0]    r_s1_count;
    logic signed [SMP_W-1:0] r_s1_ref;

    logic                r_s2_valid;
    logic                r_s2_last;
    logic                r_s2_bank;
    logic [CNT_W-1:0]    r_s2_count;
    logic [SQ_W-1:0]     r_s2_sq;

    logic                accept;
    logic                store;
    logic [CNT_W-1:0]    count_after;
    logic signed [SMP_W-1:0] ref_trunc;
    logic signed [SMP_W-1:0] mic_trunc;
    logic signed [PROD_W-1:0] sq_full;
    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] energy_sat;

    assign ref_trunc   = i_ref_raw[TRUNC_SHIFT +: SMP_W];
    assign mic_trunc   = i_mic_raw[TRUNC_SHIFT +: SMP_W];
    assign o_ready     = !r_busy[r_wbank];
    assign accept      = i_valid && o_ready;
    assign store       = accept && (r_count < CNT_W'(MAX_SAMPLES));
    assign count_after = store ? r_count + 1'b1 : r_count;

    assign o_wr_en       = store;
    assign o_wr_addr     = {r_wbank, r_count[ADDR_W-1:0]};
    assign o_ref_wr_data = ref_trunc;
    assign o_mic_wr_data = mic_trunc;

    assign sq_full    = r_s1_ref * r_s1_ref;
    assign energy_sum = {1'b0, r_energy} + (ENERGY_W + 1)'(r_s2_sq);
    assign energy_sat = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

    assign o_push            = r_s2_valid && r_s2_last;
    assign o_push_job.bank   = r_s2_bank;
    assign o_push_job.count  = r_s2_count;
    assign o_push_job.silent = !(energy_sat > ENERGY_W'(r_thr));

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = i_last ? '0 : count_after;
        end

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept && i_last) begin
            n_busy[r_wbank] = 1'b1;
        end

        n_energy = r_energy;
        if (r_s2_valid) begin
            n_energy = r_s2_last ? '0 : energy_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_count    <= '0;
            r_wbank    <= 1'b0;
            r_busy     <= '0;
            r_energy   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_thr <= i_cfg_wdata;
            end
            r_count    <= n_count;
            r_busy     <= n_busy;
            r_energy   <= n_energy;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            if (accept && i_last) begin
                r_wbank <= !r_wbank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ref   <= ref_trunc;
        r_s1_store <= store;
        r_s1_last  <= i_last;
        r_s1_bank  <= r_wbank;
        r_s1_count <= count_after;
        r_s2_sq    <= r_s1_store ? SQ_W'(sq_full) : '0;
        r_s2_last  <= r_s1_last;
        r_s2_bank  <= r_s1_bank;
        r_s2_count <= r_s1_count;
    end

endmodule

// ===== hw/rtl/cclag_back.sv =====
// ----------------------------------------------------------------------------
// Cross-correlation lag search back end
// Walks every lag of a queued batch through one shared multiply-accumulate
// pipeline, keeps the best score and holds the result for the output.
// ----------------------------------------------------------------------------
`include "cross_correlation_lag_search_assert.svh"

module cclag_back
    import cclag_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_rd_en,
    output logic [RAM_AW-1:0]     o_ref_rd_addr,
    output logic [RAM_AW-1:0]     o_mic_rd_addr,
    input  logic [SMP_W-1:0]      i_ref_rd_data,
    input  logic [SMP_W-1:0]      i_mic_rd_data,
    output t_release              o_release,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [LAG_OUT_W-1:0]  o_peak_lag,
    output logic [SCORE_W-1:0]    o_peak_score,
    output logic                  o_silent
);

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - SCORE_W + 1){1'b0}},
                                                  {(SCORE_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - SCORE_W + 1){1'b1}},
                                                  {(SCORE_W - 1){1'b0}}};

    t_back_state             r_state;
    t_back_state             n_state;
    logic signed [IDX_W-1:0] r_j;
    logic signed [IDX_W-1:0] n_j;
    logic signed [IDX_W-1:0] r_jend;
    logic signed [IDX_W-1:0] n_jend;
    logic                    r_empty;
    logic                    n_empty;
    logic signed [LAG_W-1:0] r_lag;
    logic signed [LAG_W-1:0] n_lag;
    logic                    r_bank;
    logic [CNT_W-1:0]        r_n;
    logic                    r_silent;

    logic signed [IDX_W-1:0] lag_ext;
    logic signed [IDX_W-1:0] n_ext;
    logic signed [IDX_W-1:0] j_start;
    logic signed [IDX_W-1:0] j_end;
    logic signed [IDX_W-1:0] j_next;
    logic signed [IDX_W-1:0] k_idx;
    logic                    beat;
    logic                    beat_last;
    logic                    out_load;

    logic                    r_s1_valid;
    logic                    r_s1_zero;
    logic                    r_s1_last;
    logic                    r_s1_final;
    logic signed [LAG_W-1:0] r_s1_lag;
    logic signed [PROD_W-1:0] prod;

    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic                    r_s2_final;
    logic signed [LAG_W-1:0] r_s2_lag;
    logic signed [PROD_W-1:0] r_s2_prod;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    r_s3_valid;
    logic                    r_s3_final;
    logic signed [LAG_W-1:0] r_s3_lag;
    logic signed [ACC_W-1:0] r_s3_score;

    logic signed [SCORE_W-1:0] sat_score;
    logic                    better;
    logic                    r_have;
    logic signed [SCORE_W-1:0] r_peak_score;
    logic signed [LAG_W-1:0] r_peak_lag;
    logic                    r_s4_done;
    logic signed [31:0]      lag_wide;

    logic                    r_out_valid;
    logic [LAG_OUT_W-1:0]    r_out_lag;
    logic [SCORE_W-1:0]      r_out_score;
    logic                    r_out_silent;

    assign lag_ext = IDX_W'(r_lag);
    assign n_ext   = $signed(IDX_W'(r_n));
    assign j_start = (lag_ext < 0) ? -lag_ext : '0;
    assign j_end   = (lag_ext > 0) ? n_ext - lag_ext : n_ext;
    assign j_next  = r_j + 1'b1;
    assign k_idx   = r_j + lag_ext;

    assign o_rd_en       = beat && !r_empty;
    assign o_ref_rd_addr = {r_bank, r_j[ADDR_W-1:0]};
    assign o_mic_rd_addr = {r_bank, k_idx[ADDR_W-1:0]};

    assign o_release.valid = out_load;
    assign o_release.bank  = r_bank;

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_jend    = r_jend;
        n_empty   = r_empty;
        n_lag     = r_lag;
        o_pop     = 1'b0;
        beat      = 1'b0;
        beat_last = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_lag   = FIRST_LAG;
                    n_state = BK_SETUP;
                end
            end
            BK_SETUP: begin
                n_j     = j_start;
                n_jend  = j_end;
                n_empty = (j_start >= j_end);
                n_state = BK_ISSUE;
            end
            BK_ISSUE: begin
                beat      = 1'b1;
                beat_last = r_empty || (j_next == r_jend);
                if (beat_last) begin
                    if (r_lag == LAST_LAG) begin
                        n_state = BK_DRAIN;
                    end else begin
                        n_lag   = r_lag + 1'b1;
                        n_state = BK_SETUP;
                    end
                end else begin
                    n_j = j_next;
                end
            end
            BK_DRAIN: begin
                if (r_s4_done) begin
                    n_state = BK_OUTPUT;
                end
            end
            BK_OUTPUT: begin
                if (!r_out_valid || i_m_ready) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_jend  <= n_jend;
        r_empty <= n_empty;
        r_lag   <= n_lag;
        if (o_pop) begin
            r_bank   <= i_job.bank;
            r_n      <= i_job.count;
            r_silent <= i_job.silent;
        end
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate, compare.
    assign prod      = $signed(i_mic_rd_data) * $signed(i_ref_rd_data);
    assign acc_sum   = r_acc + ACC_W'(r_s2_prod);
    assign sat_score = (r_s3_score > SAT_HI) ? SAT_HI[SCORE_W-1:0] :
                       (r_s3_score < SAT_LO) ? SAT_LO[SCORE_W-1:0] :
                       r_s3_score[SCORE_W-1:0];
    assign better    = !r_have || (sat_score > r_peak_score);
    assign lag_wide  = 32'(r_peak_lag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_done   <= 1'b0;
            r_acc       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= beat;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid && r_s2_last;
            r_s4_done   <= r_s3_valid && r_s3_final;
            r_out_valid <= out_load || (r_out_valid && !i_m_ready);
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : acc_sum;
            end
            if (o_pop) begin
                r_have <= 1'b0;
            end else if (r_s3_valid) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zero  <= r_empty;
        r_s1_last  <= beat_last;
        r_s1_final <= beat_last && (r_lag == LAST_LAG);
        r_s1_lag   <= r_lag;
        r_s2_prod  <= r_s1_zero ? '0 : prod;
        r_s2_last  <= r_s1_last;
        r_s2_final <= r_s1_final;
        r_s2_lag   <= r_s1_lag;
        r_s3_score <= acc_sum;
        r_s3_final <= r_s2_final;
        r_s3_lag   <= r_s2_lag;
        if (r_s3_valid && better) begin
            r_peak_score <= sat_score;
            r_peak_lag   <= r_s3_lag;
        end
        if (out_load) begin
            r_out_lag    <= lag_wide[LAG_OUT_W-1:0];
            r_out_score  <= r_peak_score;
            r_out_silent <= r_silent;
        end
    end

    assign o_m_valid    = r_out_valid;
    assign o_peak_lag   = r_out_lag;
    assign o_peak_score = r_out_score;
    assign o_silent     = r_out_silent;

    `CCLAG_ASSERT_NOW(a_index_in_batch, (r_state == BK_ISSUE) && !r_empty,
        (r_j < r_jend) && (k_idx >= 0) && (k_idx < n_ext),
        "sample index outside the batch")
    `CCLAG_ASSERT_NOW(a_done_while_drain, r_s4_done, r_state == BK_DRAIN,
        "final lag scored outside the drain wait")
    `CCLAG_ASSERT_NEXT(a_final_after_issue, r_s3_valid && r_s3_final,
        (r_state == BK_DRAIN) && r_s4_done,
        "final lag score arrived while samples were still issued")

endmodule

// ===== hw/rtl/cross_correlation_lag_search.sv =====
// ----------------------------------------------------------------------------
// Cross-correlation lag search
// Loads batches of paired samples and reports the lag with the highest
// correlation score, its score and a silence flag for each batch.
// ----------------------------------------------------------------------------
// Channel    Direction  Carries
// s_axis     in         ref_raw, mic_raw, last (tlast)
// m_axis     out        lag, score, silent (tuser)
// cfg        in         threshold write
//
// Loading accepts one sample per cycle while the write bank is free. The
// search walks every lag of a batch through the single shared
// multiply-accumulate unit that reads both RAMs, one overlapping sample pair
// per cycle for each lag (at least one per lag).
// Two RAM banks let the next batch load while the previous one is searched.
// The input stalls only while both banks hold batches not yet in the output.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module cross_correlation_lag_search
    import cclag_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [THR_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // ref_raw [23:0], mic_raw [47:24]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // lag [5:0], score [45:6], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // silent [0]
    output logic                   m_axis_tuser
);

    logic                 wr_en;
    logic [RAM_AW-1:0]    wr_addr;
    logic [SMP_W-1:0]     ref_wr_data;
    logic [SMP_W-1:0]     mic_wr_data;
    logic                 rd_en;
    logic [RAM_AW-1:0]    ref_rd_addr;
    logic [RAM_AW-1:0]    mic_rd_addr;
    logic [SMP_W-1:0]     ref_rd_data;
    logic [SMP_W-1:0]     mic_rd_data;
    t_release             release_bank;
    logic                 push;
    t_job                 push_job;
    logic                 pop;
    logic                 job_valid;
    t_job                 job;
    logic [LAG_OUT_W-1:0] peak_lag;
    logic [SCORE_W-1:0]   peak_score;

    cclag_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_ref_raw     (s_axis_tdata[RAW_W-1:0]),
        .i_mic_raw     (s_axis_tdata[2*RAW_W-1:RAW_W]),
        .i_last        (s_axis_tlast),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_ref_wr_data (ref_wr_data),
        .o_mic_wr_data (mic_wr_data),
        .i_release     (release_bank),
        .o_push        (push),
        .o_push_job    (push_job)
    );

    cclag_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_valid    (job_valid),
        .o_job      (job)
    );

    cclag_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (ref_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (ref_rd_addr),
        .o_rd_data (ref_rd_data)
    );

    cclag_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_mic_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (mic_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (mic_rd_addr),
        .o_rd_data (mic_rd_data)
    );

    cclag_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_pop         (pop),
        .o_rd_en       (rd_en),
        .o_ref_rd_addr (ref_rd_addr),
        .o_mic_rd_addr (mic_rd_addr),
        .i_ref_rd_data (ref_rd_data),
        .i_mic_rd_data (mic_rd_data),
        .o_release     (release_bank),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_peak_lag    (peak_lag),
        .o_peak_score  (peak_score),
        .o_silent      (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, peak_score, peak_lag};

endmodule
